// File: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Widths, command and status codes, the cell control bundle and the data
// conversion helpers used by the cell row, the read tree and the top level.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;

	// Fixed widths of the item fields.
	localparam int CMD_W    = 2;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// Element count and comparison widths.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Read-back OR tree: groups of eight cells, one register level per group.
	localparam int GRP  = 8;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} ple_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} ple_status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} ple_cell_op_t;

	typedef logic [DATA_WIDTH-1:0] ple_data_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		ple_cell_op_t      op;
		logic [CMP_W-1:0]  pos;
		ple_data_t         data;
		logic              rd_en;
	} ple_ctrl_t;

	// Input word into cell storage: truncate or sign-extend to DATA_WIDTH.
	function automatic ple_data_t to_cell(input logic signed [VALUE_W-1:0] v);
		return DATA_WIDTH'(v);
	endfunction

	// Cell word to the output field: sign-extend from DATA_WIDTH, keep 32 bits.
	function automatic logic [VALUE_W-1:0] to_out(input ple_data_t d);
		logic signed [DATA_WIDTH-1:0] s;
		s = d;
		return VALUE_W'(s);
	endfunction

endpackage

// File: rtl/ple_req_if.sv
// ----------------------------------------------------------------------------
// ple_req_if: command channel
// Valid/ready channel carrying one list command per item.
// ----------------------------------------------------------------------------
interface ple_req_if;
	logic                         valid;
	logic                         ready;
	logic [ple_pkg::CMD_W-1:0]    cmd;
	logic [ple_pkg::POS_W-1:0]    position;
	logic signed [ple_pkg::VALUE_W-1:0] value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// File: rtl/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// ple_rsp_if: result channel
// Valid/ready channel carrying status, read data and count per item.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [ple_pkg::STATUS_W-1:0]         status;
	logic signed [ple_pkg::VALUE_W-1:0]   read_value;
	logic [ple_pkg::POS_W-1:0]            count;

	modport source (output valid, output status, output read_value, output count, input ready);
	modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// File: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the shifting list
// Holds one element, takes its lower or upper neighbour on a shift and
// offers its word to the read tree when addressed.
// ----------------------------------------------------------------------------
module ple_cell (
	input  logic                      clk,
	input  logic [ple_pkg::CMP_W-1:0] idx,
	input  ple_pkg::ple_ctrl_t        ctrl,
	input  ple_pkg::ple_data_t        below,
	input  ple_pkg::ple_data_t        above,
	output ple_pkg::ple_data_t        data,
	output ple_pkg::ple_data_t        tap
);
	import ple_pkg::*;

	ple_data_t data_q;
	ple_data_t tap_s1;
	logic      at_pos;
	logic      past_pos;

	assign at_pos   = (idx == ctrl.pos);
	assign past_pos = (idx > ctrl.pos);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (at_pos) begin
					data_q <= ctrl.data;
				end else if (past_pos) begin
					data_q <= below;
				end
			end
			CELL_REMOVE: begin
				if (at_pos || past_pos) begin
					data_q <= above;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
		tap_s1 <= (ctrl.rd_en && at_pos) ? data_q : '0;
	end

	assign data = data_q;
	assign tap  = tap_s1;

endmodule

// File: rtl/ple_read_tree.sv
// ----------------------------------------------------------------------------
// ple_read_tree: registered OR tree over the cell taps
// Only the addressed cell drives a non-zero tap, so an OR gathers it.
// ----------------------------------------------------------------------------
module ple_read_tree (
	input  logic               clk,
	input  ple_pkg::ple_data_t taps [ple_pkg::CAPACITY],
	output ple_pkg::ple_data_t rd_data
);
	import ple_pkg::*;

	ple_data_t grp_in [NGRP][GRP];
	ple_data_t grp_or [NGRP];
	ple_data_t grp_s2 [NGRP];

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		for (genvar k = 0; k < GRP; k++) begin : g_mem
			if (g * GRP + k < CAPACITY) begin : g_used
				assign grp_in[g][k] = taps[g * GRP + k];
			end else begin : g_pad
				assign grp_in[g][k] = '0;
			end
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				grp_or[g] = grp_or[g] | grp_in[g][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s2 <= grp_or;
	end

	always_comb begin
		rd_data = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_data = rd_data | grp_s2[g];
		end
	end

endmodule

// File: rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list held in a row of shifting cells
// Insert, remove, read and clear by position, one result item per command.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Fields                          | Accepted when
//  --------+-----------+---------------------------------+-----------------------
//  req     | in        | cmd, position, value            | req.valid & req.ready
//  rsp     | out       | status, read_value, count       | rsp.valid & rsp.ready
//
// A command's result reaches the output register through the read path: the
// addressed cell registers its word, then a registered OR over groups of eight
// cells, then the output register. The next command enters only as that result
// is taken, so the block holds only one item in flight at a time.
// Shifts for insert and remove happen at the accepting edge, in every cell at or above the position.
// Reset clears the element count and the pipeline valid flags; cell contents
// are not reset, as only cells below the count are ever read.
// A stalled result holds in the output register; a new item is taken in the
// cycle the held result is taken.
//
module positional_list_engine_core (
	input  logic clk,
	input  logic arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);
	import ple_pkg::*;

	// Element count; the only list state that needs a reset.
	logic [CNT_W-1:0] count_q;

	// Item progress through the read path.
	logic v_s1;
	logic v_s2;

	// Status and count travel alongside the read data.
	ple_status_t      status_s1;
	ple_status_t      status_s2;
	logic [CNT_W-1:0] count_s1;
	logic [CNT_W-1:0] count_s2;

	// Output register.
	logic             out_valid_q;
	ple_status_t      out_status_q;
	logic [VALUE_W-1:0] out_read_q;
	logic [CNT_W-1:0] out_count_q;

	logic             accept;
	ple_cmd_t         cmd_e;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	ple_ctrl_t        ctrl;
	ple_status_t      status_d;
	logic [CNT_W-1:0] count_d;

	ple_data_t cell_data [CAPACITY];
	ple_data_t taps      [CAPACITY];
	ple_data_t rd_data;

	// One item in flight at a time; the output register must be free, or be
	// emptied in this same cycle, before a new command enters.
	assign req.ready = !v_s1 && !v_s2 && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign cmd_e   = ple_cmd_t'(req.cmd);
	assign pos_ext = CMP_W'(req.position);
	assign cnt_ext = CMP_W'(count_q);

	// Command decode: range and full checks, the broadcast to the cells and
	// the count after the command. An out-of-range insert is reported before
	// a full list is.
	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.pos   = pos_ext;
		ctrl.data  = to_cell(req.value);
		ctrl.rd_en = 1'b0;
		status_d   = ST_DONE;
		count_d    = count_q;
		unique case (cmd_e)
			CMD_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_d = ST_RANGE;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = CELL_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_RANGE;
				end else begin
					ctrl.op = CELL_REMOVE;
					count_d = count_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_RANGE;
				end else begin
					ctrl.rd_en = 1'b1;
				end
			end
			CMD_CLEAR: begin
				// Cells are left as they are; only the count goes.
				count_d = '0;
			end
		endcase
		if (!accept) begin
			ctrl.op    = CELL_HOLD;
			ctrl.rd_en = 1'b0;
		end
	end

	// The cell row. The end cells see themselves as the missing neighbour;
	// those values never reach a position below the count.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ple_data_t below;
		ple_data_t above;

		if (i == 0) begin : g_first
			assign below = cell_data[i];
		end else begin : g_lower
			assign below = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign above = cell_data[i];
		end else begin : g_upper
			assign above = cell_data[i+1];
		end

		ple_cell u_cell (
			.clk   (clk),
			.idx   (CMP_W'(i)),
			.ctrl  (ctrl),
			.below (below),
			.above (above),
			.data  (cell_data[i]),
			.tap   (taps[i])
		);
	end

	ple_read_tree u_read_tree (
		.clk     (clk),
		.taps    (taps),
		.rd_data (rd_data)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (v_s2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload alongside the read path.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
		if (v_s1) begin
			status_s2 <= status_s1;
			count_s2  <= count_s1;
		end
		if (v_s2) begin
			out_status_q <= status_s2;
			out_read_q   <= to_out(rd_data);
			out_count_q  <= count_s2;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_read_q;
	assign rsp.count      = POS_W'(out_count_q);

endmodule
